// ===== src/rv32i_to_rvc_compressor_unit_macros.svh =====
// ----------------------------------------------------------------------------
// RVC compressor assertion macros
// Concurrent assertion wrappers used by the compressor unit.
// ----------------------------------------------------------------------------
`ifndef RV32I_TO_RVC_COMPRESSOR_UNIT_MACROS_SVH
`define RV32I_TO_RVC_COMPRESSOR_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define RVC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rvc assertion failed");

`define RVC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rvc assertion failed");

`else

`define RVC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define RVC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/rvc_pkg.sv =====
// ----------------------------------------------------------------------------
// RVC compressor package
// Item types, opcodes and transfer class codes for the RV32I to RVC compressor.
// ----------------------------------------------------------------------------
`default_nettype none

package rvc_pkg;

    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_JAL    = 7'h6f;
    localparam logic [6:0] OP_JALR   = 7'h67;

    localparam logic [2:0] KIND_NONE   = 3'd0;
    localparam logic [2:0] KIND_CB     = 3'd1;
    localparam logic [2:0] KIND_CJ     = 3'd2;
    localparam logic [2:0] KIND_CR     = 3'd3;
    localparam logic [2:0] KIND_FULL_B = 3'd4;
    localparam logic [2:0] KIND_FULL_J = 3'd5;
    localparam logic [2:0] KIND_FULL_R = 3'd6;

    typedef struct packed {
        logic [31:0] instruction;
        logic [11:0] position;
    } rvc_in_t;

    typedef struct packed {
        logic        compressed_ok;
        logic [15:0] compressed_word;
        logic [2:0]  transfer_kind;
        logic [11:0] position_out;
    } rvc_out_t;

    function automatic logic is_prime(input logic [4:0] r);
        return r[4:3] == 2'b01;
    endfunction

endpackage

`default_nettype wire

// ===== src/rvc_in_stage.sv =====
// ----------------------------------------------------------------------------
// RVC input stage
// Registers one instruction item and hands it to the encoder.
// ----------------------------------------------------------------------------
`default_nettype none

module rvc_in_stage (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           up_valid,
    output logic                up_ready,
    input  wire rvc_pkg::rvc_in_t up_data,
    output logic                dn_valid,
    input  wire logic           dn_ready,
    output rvc_pkg::rvc_in_t    dn_data
);
    import rvc_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    rvc_in_t data_reg;

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (up_valid && up_ready)
        begin
            valid_next = 1'b1;
        end
        else if (dn_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= up_data;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

`default_nettype wire

// ===== src/rvc_enc.sv =====
// ----------------------------------------------------------------------------
// RVC encoder
// Re-encodes one RV32I word as a 16-bit RVC word where it can (zero otherwise) and classifies transfers.
// ----------------------------------------------------------------------------
`default_nettype none

module rvc_enc (
    input  wire rvc_pkg::rvc_in_t enc_in,
    output rvc_pkg::rvc_out_t     enc_out
);
    import rvc_pkg::*;

    logic [31:0] w;
    logic [6:0]  opc;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [6:0]  f7;
    logic [11:0] imm;
    logic        small_imm;
    logic [19:0] u;
    logic [11:0] boff;
    logic [11:0] joff;
    logic [1:0]  alu_sel;
    logic [15:0] word;
    logic [2:0]  kind;

    assign w         = enc_in.instruction;
    assign opc       = w[6:0];
    assign rd        = w[11:7];
    assign f3        = w[14:12];
    assign rs1       = w[19:15];
    assign rs2       = w[24:20];
    assign f7        = w[31:25];
    assign imm       = w[31:20];
    assign small_imm = (f7 == 7'h00) || (f7 == 7'h7f);
    assign u         = w[31:12];
    assign boff      = {w[7], w[30:25], w[11:8], 1'b0};
    assign joff      = {w[20], w[30:21], 1'b0};
    assign alu_sel   = (f3 == 3'd7) ? 2'd3 : (f3 == 3'd6) ? 2'd2 : (f3 == 3'd4) ? 2'd1 : 2'd0;

    always_comb
    begin
        word = 16'h0000;
        kind = KIND_NONE;
        unique case (opc)
            OP_REG:
            begin
                priority if (f3 == 3'd0 && f7 == 7'h00 && rd != 5'd0 && rs2 != 5'd0)
                begin
                    if (rs1 == rd)
                        word = {4'b1001, rd, rs2, 2'b10};
                    else if (rs1 == 5'd0)
                        word = {4'b1000, rd, rs2, 2'b10};
                end
                else if (rd == rs1 && is_prime(rd) && is_prime(rs2) &&
                         ((f7 == 7'h00 && (f3 == 3'd7 || f3 == 3'd6 || f3 == 3'd4)) ||
                          (f7 == 7'h20 && f3 == 3'd0)))
                begin
                    word = {6'b100011, rd[2:0], alu_sel, rs2[2:0], 2'b01};
                end
                else
                begin
                    word = 16'h0000;
                end
            end
            OP_IMM:
            begin
                priority if (f3 == 3'd0 && rd != 5'd0 && rs1 == 5'd0 && small_imm)
                    word = {3'b010, imm[5], rd, imm[4:0], 2'b01};
                else if (f3 == 3'd0 && rd != 5'd0 && rs1 == rd && imm != 12'd0 && small_imm)
                    word = {3'b000, imm[5], rd, imm[4:0], 2'b01};
                else if (f3 == 3'd1 && f7 == 7'h00 && rd != 5'd0 && rs1 == rd)
                    word = {3'b000, imm[5], rd, imm[4:0], 2'b10};
                else if (f3 == 3'd5 && f7 == 7'h00 && is_prime(rd) && rs1 == rd)
                    word = {3'b100, imm[5], 2'b00, rd[2:0], imm[4:0], 2'b01};
                else if (f3 == 3'd5 && f7 == 7'h20 && is_prime(rd) && rs1 == rd)
                    word = {3'b100, 1'b0, 2'b01, rd[2:0], imm[4:0], 2'b01};
                else if (f3 == 3'd7 && is_prime(rd) && rs1 == rd && small_imm)
                    word = {3'b100, imm[5], 2'b10, rd[2:0], imm[4:0], 2'b01};
                else
                    word = 16'h0000;
            end
            OP_LOAD:
            begin
                if (!imm[11] && f3 == 3'd2 && is_prime(rd) && is_prime(rs1) &&
                    imm[1:0] == 2'b00 && imm[11:7] == 5'd0)
                begin
                    word = {3'b010, imm[5:3], rs1[2:0], imm[2], imm[6], rd[2:0], 2'b00};
                end
            end
            OP_LUI:
            begin
                if (rd != 5'd0 && rd != 5'd2 && u != 20'd0 &&
                    (u[19:5] == 15'h0000 || u[19:5] == 15'h7fff))
                begin
                    word = {3'b011, u[5], rd, u[4:0], 2'b01};
                end
            end
            OP_STORE:
            begin
                if (f3 == 3'd2 && is_prime(rs1) && is_prime(rs2) &&
                    rd[1:0] == 2'b00 && f7[6:2] == 5'd0)
                begin
                    word = {3'b110, f7[0], rd[4:3], rs1[2:0], rd[2], f7[1], rs2[2:0], 2'b00};
                end
            end
            OP_BRANCH:
            begin
                if ((f3 == 3'd0 || f3 == 3'd1) && is_prime(rs1) && rs2 == 5'd0)
                begin
                    kind = KIND_CB;
                    word = {2'b11, f3[0], boff[8], boff[4:3], rs1[2:0],
                            boff[7:6], boff[2:1], boff[5], 2'b01};
                end
                else
                begin
                    kind = KIND_FULL_B;
                end
            end
            OP_JAL:
            begin
                if (rd[4:1] == 4'd0)
                begin
                    kind = KIND_CJ;
                    word = {!rd[0], 2'b01, joff[11], joff[4], joff[9:8], joff[10],
                            joff[6], joff[7], joff[3:1], joff[5], 2'b01};
                end
                else
                begin
                    kind = KIND_FULL_J;
                end
            end
            OP_JALR:
            begin
                if (rs1 != 5'd0 && f3 == 3'd0 && imm == 12'd0 && rd[4:1] == 4'd0)
                begin
                    kind = KIND_CR;
                    word = {3'b100, rd[0], rs1, 5'd0, 2'b10};
                end
                else
                begin
                    kind = KIND_FULL_R;
                end
            end
            default:
            begin
                word = 16'h0000;
                kind = KIND_NONE;
            end
        endcase
    end

    assign enc_out.compressed_ok   = |word;
    assign enc_out.compressed_word = word;
    assign enc_out.transfer_kind   = kind;
    assign enc_out.position_out    = enc_in.position;

endmodule

`default_nettype wire

// ===== src/rvc_out_stage.sv =====
// ----------------------------------------------------------------------------
// RVC output stage
// Registers one result item and holds it until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rvc_out_stage (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            up_valid,
    output logic                 up_ready,
    input  wire rvc_pkg::rvc_out_t up_data,
    output logic                 dn_valid,
    input  wire logic            dn_ready,
    output rvc_pkg::rvc_out_t    dn_data
);
    import rvc_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    rvc_out_t data_reg;

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (up_valid && up_ready)
        begin
            valid_next = 1'b1;
        end
        else if (dn_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= up_data;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

`default_nettype wire

// ===== src/rv32i_to_rvc_compressor_unit.sv =====
// ----------------------------------------------------------------------------
// RV32I to RVC compressor unit
// Takes RV32I instruction items, gives RVC results with a transfer class.
// ----------------------------------------------------------------------------
// Usage:
//   instr channel: instr_valid / instr_ready carry one instruction word and
//   its program position. result channel: result_valid / result_ready carry
//   the success flag, the 16-bit RVC word (zero when not compressed), the
//   transfer class code and the echoed position.
//   Path: result_valid rises once the item has passed the input register and
//   then the result register around the combinational encoder; a stall can
//   hold the item in the input register on the way.
//   Throughput: one item per cycle while result_ready stays high.
//   Reset: both stages empty; instr_ready high, result_valid low.
//   Stall: with result_ready low the result holds; the input register still
//   takes one more item, after which instr_ready drops until the result is
//   taken. Items are never dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rv32i_to_rvc_compressor_unit_macros.svh"

module rv32i_to_rvc_compressor_unit (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             instr_valid,
    output logic                  instr_ready,
    input  wire rvc_pkg::rvc_in_t instr,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output rvc_pkg::rvc_out_t     result
);
    import rvc_pkg::*;

    logic     enc_valid;
    logic     enc_ready;
    rvc_in_t  enc_in;
    rvc_out_t enc_out;

    logic     ok_consistent;
    logic     quadrant_ok;
    logic     short_kind;
    logic     full_kind;
    logic     taken_flowing;

    rvc_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (instr_valid),
        .up_ready (instr_ready),
        .up_data  (instr),
        .dn_valid (enc_valid),
        .dn_ready (enc_ready),
        .dn_data  (enc_in)
    );

    rvc_enc u_enc (
        .enc_in  (enc_in),
        .enc_out (enc_out)
    );

    rvc_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (enc_valid),
        .up_ready (enc_ready),
        .up_data  (enc_out),
        .dn_valid (result_valid),
        .dn_ready (result_ready),
        .dn_data  (result)
    );

    assign ok_consistent = result.compressed_ok == (result.compressed_word != 16'h0000);
    assign quadrant_ok   = result.compressed_word[1:0] != 2'b11;
    assign short_kind    = result.transfer_kind == KIND_CB ||
                           result.transfer_kind == KIND_CJ ||
                           result.transfer_kind == KIND_CR;
    assign full_kind     = result.transfer_kind == KIND_FULL_B ||
                           result.transfer_kind == KIND_FULL_J ||
                           result.transfer_kind == KIND_FULL_R;
    assign taken_flowing = instr_valid && instr_ready && result_ready;

    `RVC_ASSERT_IMPLIES(a_ok_matches_word, clk, rst_n, result_valid, ok_consistent)
    `RVC_ASSERT_IMPLIES(a_rvc_quadrant, clk, rst_n, result_valid && result.compressed_ok, quadrant_ok)
    `RVC_ASSERT_IMPLIES(a_short_kind_ok, clk, rst_n, result_valid && short_kind, result.compressed_ok)
    `RVC_ASSERT_IMPLIES(a_full_kind_not_ok, clk, rst_n, result_valid && full_kind, !result.compressed_ok)
    `RVC_ASSERT_IMPLIES(a_no_stall_when_drained, clk, rst_n, result_ready, instr_ready)
    `RVC_ASSERT_NEXT(a_two_cycle_latency, clk, rst_n, taken_flowing ##1 result_ready, result_valid)

endmodule

`default_nettype wire
